### hdl/wc2d_pkg.sv
// Shared constants and types for the wrapped 2-D convolution block.
package wc2d_pkg;

   localparam int MAX_TILE       = 256;
   localparam int MAX_RADIUS     = 7;
   localparam int COEF_FRAC_BITS = 12;

   localparam int KSIDE   = 2 * MAX_RADIUS + 1;
   localparam int KDEPTH  = KSIDE * KSIDE;
   localparam int TDEPTH  = MAX_TILE * MAX_TILE;

   localparam int COORD_W = 8;
   localparam int SIZE_W  = 9;
   localparam int RAD_W   = 3;
   localparam int KIDX_W  = 4;
   localparam int PIX_W   = 8;
   localparam int COEF_W  = 16;
   localparam int KADDR_W = $clog2(KDEPTH);
   localparam int TADDR_W = 2 * COORD_W;
   localparam int PROD_W  = PIX_W + 1 + COEF_W;
   localparam int ACC_W   = 32;
   localparam int DIV_W   = SIZE_W + COORD_W;
   localparam int STEP_W  = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] ACT_LOAD_COEF  = 2'd0;
   localparam logic [1:0] ACT_LOAD_PIXEL = 2'd1;
   localparam logic [1:0] ACT_COMPUTE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_H  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_V  = 2'd2;

   localparam logic [STEP_W-1:0] CENTRE_LAST = STEP_W'(COORD_W);

   typedef struct packed {
      logic clear;
      logic tap;
   } mac_ctrl_type;

endpackage

### hdl/wc2d_ram.sv
// Generic simple dual-port RAM with registered read.
module wc2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/wc2d_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
module wc2d_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  wc2d_pkg::mac_ctrl_type              ctrl,
   input  logic [wc2d_pkg::PIX_W-1:0]          pix,
   input  logic signed [wc2d_pkg::COEF_W-1:0]  coef,
   output logic signed [wc2d_pkg::ACC_W-1:0]   acc,
   output logic                                busy
);

   logic signed [wc2d_pkg::PROD_W-1:0] prod_ff;
   logic signed [wc2d_pkg::PROD_W-1:0] prod_in;
   logic                               prod_v_ff;
   logic signed [wc2d_pkg::ACC_W-1:0]  acc_ff;
   logic signed [wc2d_pkg::ACC_W-1:0]  acc_in;

   always_comb begin
      prod_in = wc2d_pkg::PROD_W'($signed({1'b0, pix}) * coef);
      acc_in  = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_v_ff) begin
         acc_in = acc_ff + wc2d_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= ctrl.tap;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = prod_v_ff;

endmodule

### hdl/wrapped_2d_convolution.sv
// Top level of the wrapped 2-D convolution engine.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/req_stall + action, coords, val | in
//  rsp     | rsp_valid/rsp_stall + pixel, coords       | out
//  csr     | csr_write, csr_index, csr_data            | in
//
// Loads are written as they are taken. A compute item holds req_stall through centre
// wrapping (one remainder bit per cycle), a walk to the window corner,
// (2*rh+1)*(2*rv+1) taps through the shared MAC at one per cycle, a drain of the
// read and MAC registers and the hand-over to the output register.
// Reset clears the control state and the radii and sets the tile size to MAX_TILE; stores are undefined.
// req_stall is high for the whole of a compute item and while a result
// waits for a full output register.
module wrapped_2d_convolution (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_action,
   input  logic [wc2d_pkg::COORD_W-1:0]             req_coord_first,
   input  logic [wc2d_pkg::COORD_W-1:0]             req_coord_second,
   input  logic signed [wc2d_pkg::COEF_W-1:0]       req_load_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [wc2d_pkg::PIX_W-1:0]               rsp_pixel_out,
   output logic [wc2d_pkg::COORD_W-1:0]             rsp_out_first,
   output logic [wc2d_pkg::COORD_W-1:0]             rsp_out_second,
   input  logic                                     csr_write,
   input  logic [wc2d_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [wc2d_pkg::SIZE_W-1:0]              csr_data
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CENTRE = 6'b000010,
      S_START  = 6'b000100,
      S_SCAN   = 6'b001000,
      S_DRAIN  = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [wc2d_pkg::SIZE_W-1:0]  tile_size_ff;
   logic [wc2d_pkg::RAD_W-1:0]   rad_h_ff;
   logic [wc2d_pkg::RAD_W-1:0]   rad_v_ff;
   logic [wc2d_pkg::SIZE_W-1:0]  size_eff;
   logic [wc2d_pkg::COORD_W-1:0] size_last;

   logic [wc2d_pkg::COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [wc2d_pkg::COORD_W-1:0] px_ff, px_in, py_ff, py_in, py0_ff, py0_in;
   logic [wc2d_pkg::DIV_W-1:0]   dsor_ff, dsor_in;
   logic [wc2d_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [wc2d_pkg::RAD_W-1:0]   walk_x_ff, walk_x_in, walk_y_ff, walk_y_in;
   logic [wc2d_pkg::KIDX_W-1:0]  kx_ff, kx_in, ky_ff, ky_in;
   logic [wc2d_pkg::KADDR_W-1:0] kbase_ff, kbase_in, kaddr_ff, kaddr_in;
   logic [wc2d_pkg::KIDX_W-1:0]  kx_last, ky_last;
   logic                         rd_v_ff;
   logic [wc2d_pkg::COORD_W-1:0] cap_first_ff, cap_second_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [wc2d_pkg::PIX_W-1:0]   rsp_pixel_ff, rsp_pixel_in;
   logic [wc2d_pkg::COORD_W-1:0] rsp_first_ff, rsp_first_in;
   logic [wc2d_pkg::COORD_W-1:0] rsp_second_ff, rsp_second_in;

   logic                         req_take;
   logic                         tile_we, kern_we;
   logic [wc2d_pkg::KADDR_W-1:0] kern_wr_addr;
   logic [wc2d_pkg::PIX_W-1:0]   tile_rd_data;
   logic [wc2d_pkg::COEF_W-1:0]  kern_rd_data;
   logic [wc2d_pkg::COORD_W-1:0] rem_x_sub, rem_y_sub;
   logic [wc2d_pkg::COORD_W-1:0] px_inc, py_inc;
   logic [wc2d_pkg::PIX_W-1:0]   clamped;

   wc2d_pkg::mac_ctrl_type       mac_ctrl;
   logic signed [wc2d_pkg::ACC_W-1:0] mac_acc;
   logic                         mac_busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff <= wc2d_pkg::SIZE_W'(wc2d_pkg::MAX_TILE);
         rad_h_ff     <= '0;
         rad_v_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            wc2d_pkg::CSR_TILE_SIZE: tile_size_ff <= csr_data;
            wc2d_pkg::CSR_RADIUS_H:  rad_h_ff     <= csr_data[wc2d_pkg::RAD_W-1:0];
            wc2d_pkg::CSR_RADIUS_V:  rad_v_ff     <= csr_data[wc2d_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      size_eff = tile_size_ff;
      if (tile_size_ff == '0) begin
         size_eff = wc2d_pkg::SIZE_W'(1);
      end else if (tile_size_ff > wc2d_pkg::SIZE_W'(wc2d_pkg::MAX_TILE)) begin
         size_eff = wc2d_pkg::SIZE_W'(wc2d_pkg::MAX_TILE);
      end
   end

   assign size_last = wc2d_pkg::COORD_W'(size_eff - wc2d_pkg::SIZE_W'(1));
   assign kx_last   = wc2d_pkg::KIDX_W'({rad_h_ff, 1'b0});
   assign ky_last   = wc2d_pkg::KIDX_W'({rad_v_ff, 1'b0});

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // loads
   assign tile_we = req_take && (req_action == wc2d_pkg::ACT_LOAD_PIXEL);
   assign kern_we = req_take && (req_action == wc2d_pkg::ACT_LOAD_COEF)
                    && (32'(req_coord_first) < wc2d_pkg::KSIDE)
                    && (32'(req_coord_second) < wc2d_pkg::KSIDE);
   assign kern_wr_addr = wc2d_pkg::KADDR_W'(32'(req_coord_first) * wc2d_pkg::KSIDE
                                            + 32'(req_coord_second));

   // one restoring remainder step per cycle on both centre coordinates
   assign rem_x_sub = cx_ff - dsor_ff[wc2d_pkg::COORD_W-1:0];
   assign rem_y_sub = cy_ff - dsor_ff[wc2d_pkg::COORD_W-1:0];

   assign px_inc = (wc2d_pkg::SIZE_W'(px_ff) + wc2d_pkg::SIZE_W'(1) == size_eff)
                   ? '0 : px_ff + wc2d_pkg::COORD_W'(1);
   assign py_inc = (wc2d_pkg::SIZE_W'(py_ff) + wc2d_pkg::SIZE_W'(1) == size_eff)
                   ? '0 : py_ff + wc2d_pkg::COORD_W'(1);

   // floor and clamp
   always_comb begin
      clamped = mac_acc[wc2d_pkg::COEF_FRAC_BITS +: wc2d_pkg::PIX_W];
      if (mac_acc <= 0) begin
         clamped = '0;
      end else if (mac_acc[wc2d_pkg::ACC_W-1:wc2d_pkg::COEF_FRAC_BITS+wc2d_pkg::PIX_W]
                   != '0) begin
         clamped = '1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      py0_in        = py0_ff;
      dsor_in       = dsor_ff;
      step_in       = step_ff;
      walk_x_in     = walk_x_ff;
      walk_y_in     = walk_y_ff;
      kx_in         = kx_ff;
      ky_in         = ky_ff;
      kbase_in      = kbase_ff;
      kaddr_in      = kaddr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      mac_ctrl      = '{clear: 1'b0, tap: rd_v_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_take && (req_action == wc2d_pkg::ACT_COMPUTE)) begin
               cx_in    = req_coord_first;
               cy_in    = req_coord_second;
               dsor_in  = {size_eff, wc2d_pkg::COORD_W'(0)};
               step_in  = '0;
               state_in = S_CENTRE;
            end
         end
         S_CENTRE: begin
            if (wc2d_pkg::DIV_W'(cx_ff) >= dsor_ff) begin
               cx_in = rem_x_sub;
            end
            if (wc2d_pkg::DIV_W'(cy_ff) >= dsor_ff) begin
               cy_in = rem_y_sub;
            end
            dsor_in = dsor_ff >> 1;
            step_in = step_ff + wc2d_pkg::STEP_W'(1);
            if (step_ff == wc2d_pkg::CENTRE_LAST) begin
               px_in     = cx_in;
               py_in     = cy_in;
               walk_x_in = rad_h_ff;
               walk_y_in = rad_v_ff;
               state_in  = S_START;
            end
         end
         S_START: begin
            mac_ctrl.clear = 1'b1;
            if (walk_x_ff != '0) begin
               px_in     = (px_ff == '0) ? size_last : px_ff - wc2d_pkg::COORD_W'(1);
               walk_x_in = walk_x_ff - wc2d_pkg::RAD_W'(1);
            end
            if (walk_y_ff != '0) begin
               py_in     = (py_ff == '0) ? size_last : py_ff - wc2d_pkg::COORD_W'(1);
               walk_y_in = walk_y_ff - wc2d_pkg::RAD_W'(1);
            end
            if ((walk_x_ff == '0) && (walk_y_ff == '0)) begin
               py0_in   = py_ff;
               kx_in    = '0;
               ky_in    = '0;
               kbase_in = '0;
               kaddr_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (ky_ff == ky_last) begin
               ky_in    = '0;
               py_in    = py0_ff;
               kx_in    = kx_ff + wc2d_pkg::KIDX_W'(1);
               px_in    = px_inc;
               kbase_in = kbase_ff + wc2d_pkg::KADDR_W'(wc2d_pkg::KSIDE);
               kaddr_in = kbase_ff + wc2d_pkg::KADDR_W'(wc2d_pkg::KSIDE);
               if (kx_ff == kx_last) begin
                  state_in = S_DRAIN;
               end
            end else begin
               ky_in    = ky_ff + wc2d_pkg::KIDX_W'(1);
               py_in    = py_inc;
               kaddr_in = kaddr_ff + wc2d_pkg::KADDR_W'(1);
            end
         end
         S_DRAIN: begin
            if (!rd_v_ff && !mac_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_pixel_in  = clamped;
               rsp_first_in  = cap_first_ff;
               rsp_second_in = cap_second_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // item coordinates as given, held for the result
   always_ff @(posedge clock) begin
      if (req_take && (req_action == wc2d_pkg::ACT_COMPUTE)) begin
         cap_first_ff  <= req_coord_first;
         cap_second_ff <= req_coord_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_v_ff      <= (state_ff == S_SCAN);
      end
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      py0_ff        <= py0_in;
      dsor_ff       <= dsor_in;
      step_ff       <= step_in;
      walk_x_ff     <= walk_x_in;
      walk_y_ff     <= walk_y_in;
      kx_ff         <= kx_in;
      ky_ff         <= ky_in;
      kbase_ff      <= kbase_in;
      kaddr_ff      <= kaddr_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   wc2d_ram #(
      .WIDTH (wc2d_pkg::PIX_W),
      .DEPTH (wc2d_pkg::TDEPTH)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (tile_we),
      .wr_addr ({req_coord_first, req_coord_second}),
      .wr_data (req_load_value[wc2d_pkg::PIX_W-1:0]),
      .rd_addr ({px_ff, py_ff}),
      .rd_data (tile_rd_data)
   );

   wc2d_ram #(
      .WIDTH (wc2d_pkg::COEF_W),
      .DEPTH (wc2d_pkg::KDEPTH)
   ) u_kern_ram (
      .clock   (clock),
      .wr_en   (kern_we),
      .wr_addr (kern_wr_addr),
      .wr_data (req_load_value),
      .rd_addr (kaddr_ff),
      .rd_data (kern_rd_data)
   );

   wc2d_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .pix   (tile_rd_data),
      .coef  ($signed(kern_rd_data)),
      .acc   (mac_acc),
      .busy  (mac_busy)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_out_first  = rsp_first_ff;
   assign rsp_out_second = rsp_second_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_scan_in_tile: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |->
         (wc2d_pkg::SIZE_W'(px_ff) < size_eff) && (wc2d_pkg::SIZE_W'(py_ff) < size_eff))
      else $error("tap coordinate outside the tile");

   a_scan_in_kernel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (kx_ff <= kx_last) && (ky_ff <= ky_last))
      else $error("kernel index outside the window");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> !rd_v_ff && !mac_busy)
      else $error("result taken before the accumulator settled");

   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_action == wc2d_pkg::ACT_COMPUTE) |=> (state_ff == S_CENTRE))
      else $error("compute item did not start the sequencer");

endmodule
